[sv/lrc_pkg.sv]
// Shared types, constants and helpers for the line rectangle clipper.
`timescale 1ns / 1ps
package lrc_pkg;

	// edge lanes in crossing order: top, left, bottom, right
	localparam int LANES = 4;
	localparam int LANE_TOP = 0;
	localparam int LANE_LEFT = 1;
	localparam int LANE_BOTTOM = 2;
	localparam int LANE_RIGHT = 3;

	// quotient bits kept; anything above the hold limit is clamped to it
	localparam int QBITS = 41;
	localparam int NUM_W = 64;
	localparam int DEN_W = 32;
	localparam int REM_W = 31;
	localparam logic [QBITS-1:0] HOLD_LIMIT = {1'b1, {(QBITS-1){1'b0}}};

	// configuration register indexes
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_LEFT = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 8'd3;

	// per-line info that rides along the divider pipeline
	typedef struct packed {
		logic                line_ok;
		logic                horiz;
		logic                vert;
		logic [LANES-1:0]    neg;
		logic signed [31:0]  px;
		logic signed [31:0]  py;
	} side_t;

	// saturate a wide signed coordinate to 32 bits
	function automatic logic [31:0] sat32(input logic signed [42:0] v);
		if (v > 43'sd2147483647)
			return 32'h7FFF_FFFF;
		else if (v < -43'sd2147483648)
			return 32'h8000_0000;
		else
			return v[31:0];
	endfunction

endpackage

[sv/lrc_divider.sv]
// Pipelined radix-2 divider, four lanes, one quotient bit per stage, clamped.
`timescale 1ns / 1ps
module lrc_divider (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic [lrc_pkg::NUM_W-1:0]           num [lrc_pkg::LANES],
	input  logic [lrc_pkg::DEN_W-1:0]           den [lrc_pkg::LANES],
	input  lrc_pkg::side_t                      side_in,
	output logic                                out_valid,
	output logic [lrc_pkg::QBITS-1:0]           quo [lrc_pkg::LANES],
	output lrc_pkg::side_t                      side_out
);

	localparam int NS = lrc_pkg::QBITS;
	localparam int REM_W = lrc_pkg::REM_W;

	logic                          v_s    [NS+1];
	lrc_pkg::side_t                side_s [NS+1];
	logic [lrc_pkg::REM_W-1:0]     rem_s  [NS+1][lrc_pkg::LANES];
	logic [lrc_pkg::QBITS-1:0]     nq_s   [NS+1][lrc_pkg::LANES];
	logic [lrc_pkg::DEN_W-1:0]     den_s  [NS+1][lrc_pkg::LANES];
	logic                          ovf_s  [NS+1][lrc_pkg::LANES];

	// load: high numerator bits seed the remainder, overflow if they reach the divisor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			for (int k = 0; k < lrc_pkg::LANES; k++) begin
				rem_s[0][k] <= {8'd0, num[k][63:41]};
				nq_s[0][k]  <= num[k][40:0];
				den_s[0][k] <= den[k];
				ovf_s[0][k] <= {9'd0, num[k][63:41]} >= den[k];
			end
		end
	end

	// one restoring step per stage
	for (genvar s = 0; s < NS; s++) begin : g_step
		logic [lrc_pkg::DEN_W-1:0] trial [lrc_pkg::LANES];
		logic                      take  [lrc_pkg::LANES];

		always_comb begin
			for (int k = 0; k < lrc_pkg::LANES; k++) begin
				trial[k] = {rem_s[s][k], nq_s[s][k][lrc_pkg::QBITS-1]};
				take[k]  = trial[k] >= den_s[s][k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[s+1] <= 1'b0;
			end else if (en) begin
				v_s[s+1] <= v_s[s];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[s+1] <= side_s[s];
				for (int k = 0; k < lrc_pkg::LANES; k++) begin
					rem_s[s+1][k] <= take[k] ? REM_W'(trial[k] - den_s[s][k])
						: trial[k][lrc_pkg::REM_W-1:0];
					nq_s[s+1][k]  <= {nq_s[s][k][lrc_pkg::QBITS-2:0], take[k]};
					den_s[s+1][k] <= den_s[s][k];
					ovf_s[s+1][k] <= ovf_s[s][k];
				end
			end
		end
	end

	// clamp at the hold limit
	always_comb begin
		for (int k = 0; k < lrc_pkg::LANES; k++) begin
			if (ovf_s[NS][k] || nq_s[NS][k] > lrc_pkg::HOLD_LIMIT)
				quo[k] = lrc_pkg::HOLD_LIMIT;
			else
				quo[k] = nq_s[NS][k];
		end
	end

	assign out_valid = v_s[NS];
	assign side_out  = side_s[NS];

endmodule

[sv/line_rectangle_clip_core.sv]
// Top level: clips one line per beat against the configured rectangle.
//
//  channel  dir  beat carries
//  s_*      in   tuser: line_valid; tdata: dir_x, dir_y, point_x, point_y
//  m_*      out  tuser: crosses; tdata: end0_x, end0_y, end1_x, end1_y
//  cfg_*    in   cfg_index, cfg_data: rect_left, rect_top, rect_width, rect_height
//
// One line enters per cycle unless the output stalls. The 41 quotient-bit stages of
// the four-lane divider set the depth. The whole pipeline advances when the
// output register is empty or taken; a stall freezes every stage.
// arst_n clears all valid bits and the rectangle to zero.
`timescale 1ns / 1ps
module line_rectangle_clip_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [127:0]  s_tdata,   // dir_x, dir_y, point_x, point_y
	input  logic [0:0]    s_tuser,   // line_valid
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [127:0]  m_tdata,   // end0_x, end0_y, end1_x, end1_y
	output logic [0:0]    m_tuser,   // crosses
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [lrc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]   cfg_data
);

	logic signed [31:0] left_q, top_q;
	logic [30:0]        width_q, height_q;
	logic signed [32:0] right, bottom;
	logic               en;

	// configuration writes
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			top_q    <= '0;
			width_q  <= '0;
			height_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				lrc_pkg::CFG_LEFT:   left_q   <= cfg_data;
				lrc_pkg::CFG_TOP:    top_q    <= cfg_data;
				lrc_pkg::CFG_WIDTH:  width_q  <= cfg_data[30:0];
				lrc_pkg::CFG_HEIGHT: height_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	assign right  = {left_q[31], left_q} + {2'b00, width_q};
	assign bottom = {top_q[31], top_q} + {2'b00, height_q};

	// advance when the output register is free
	logic out_v_s46;
	assign en       = !out_v_s46 || m_tready;
	assign s_tready = en;

	// stage 1: edge distances, magnitudes and signs
	logic signed [31:0] dx, dy, px, py;
	assign dx = s_tdata[31:0];
	assign dy = s_tdata[63:32];
	assign px = s_tdata[95:64];
	assign py = s_tdata[127:96];

	logic signed [32:0] edge_v [lrc_pkg::LANES];
	logic signed [31:0] df [lrc_pkg::LANES];
	logic signed [31:0] dd [lrc_pkg::LANES];
	logic signed [31:0] pd [lrc_pkg::LANES];
	logic signed [33:0] diff [lrc_pkg::LANES];
	lrc_pkg::side_t     side_c;

	always_comb begin
		edge_v[lrc_pkg::LANE_TOP]    = {top_q[31], top_q};
		edge_v[lrc_pkg::LANE_LEFT]   = {left_q[31], left_q};
		edge_v[lrc_pkg::LANE_BOTTOM] = bottom;
		edge_v[lrc_pkg::LANE_RIGHT]  = right;
		side_c.line_ok = s_tuser[0] && (dx != 0 || dy != 0);
		side_c.horiz   = dy == 0;
		side_c.vert    = dx == 0;
		side_c.px      = px;
		side_c.py      = py;
		for (int k = 0; k < lrc_pkg::LANES; k++) begin
			// even lanes are horizontal edges: free coordinate x
			df[k]   = k[0] ? dy : dx;
			dd[k]   = k[0] ? dx : dy;
			pd[k]   = k[0] ? px : py;
			diff[k] = {edge_v[k][32], edge_v[k]} - {{2{pd[k][31]}}, pd[k]};
			side_c.neg[k] = (df[k] != 0) && (diff[k] != 0)
				&& ((df[k][31] ^ diff[k][33]) ^ dd[k][31]);
		end
	end

	logic                 v_s1;
	lrc_pkg::side_t       side_s1;
	logic [31:0]          mdf_s1  [lrc_pkg::LANES];
	logic [32:0]          mdif_s1 [lrc_pkg::LANES];
	logic [31:0]          mdd_s1  [lrc_pkg::LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_c;
			for (int k = 0; k < lrc_pkg::LANES; k++) begin
				mdf_s1[k]  <= df[k][31] ? 32'(-df[k]) : df[k];
				mdd_s1[k]  <= dd[k][31] ? 32'(-dd[k]) : dd[k];
				mdif_s1[k] <= diff[k][33] ? 33'(-diff[k]) : diff[k][32:0];
			end
		end
	end

	// stage 2: exact products
	logic                 v_s2;
	lrc_pkg::side_t       side_s2;
	logic [63:0]          prod_s2 [lrc_pkg::LANES];
	logic [31:0]          mdd_s2  [lrc_pkg::LANES];
	logic [64:0]          prod_full [lrc_pkg::LANES];

	always_comb begin
		for (int k = 0; k < lrc_pkg::LANES; k++)
			prod_full[k] = mdf_s1[k] * mdif_s1[k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_s1;
			for (int k = 0; k < lrc_pkg::LANES; k++) begin
				prod_s2[k] <= prod_full[k][63:0];
				mdd_s2[k]  <= mdd_s1[k];
			end
		end
	end

	// stages 3 to 44: division
	logic                        v_s44;
	lrc_pkg::side_t              side_s44;
	logic [lrc_pkg::QBITS-1:0]   q_s44 [lrc_pkg::LANES];

	lrc_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.num       (prod_s2),
		.den       (mdd_s2),
		.side_in   (side_s2),
		.out_valid (v_s44),
		.quo       (q_s44),
		.side_out  (side_s44)
	);

	// stage 45: free coordinate of each crossing
	logic                 v_s45;
	lrc_pkg::side_t       side_s45;
	logic signed [42:0]   hit_s45 [lrc_pkg::LANES];
	logic signed [42:0]   pf43 [lrc_pkg::LANES];
	logic signed [42:0]   q43  [lrc_pkg::LANES];

	always_comb begin
		for (int k = 0; k < lrc_pkg::LANES; k++) begin
			pf43[k] = k[0] ? 43'(side_s44.py) : 43'(side_s44.px);
			q43[k]  = {2'b00, q_s44[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s45 <= 1'b0;
		end else if (en) begin
			v_s45 <= v_s44;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s45 <= side_s44;
			for (int k = 0; k < lrc_pkg::LANES; k++)
				hit_s45[k] <= side_s44.neg[k] ? pf43[k] - q43[k] : pf43[k] + q43[k];
		end
	end

	// stage 46: span test, end selection, saturation
	logic signed [42:0] lft, rgt, tp, bot;
	logic signed [42:0] cx [lrc_pkg::LANES];
	logic signed [42:0] cy [lrc_pkg::LANES];
	logic [lrc_pkg::LANES-1:0] ok;
	logic signed [42:0] e0x, e0y, e1x, e1y;
	logic               crs;
	logic               seen;

	always_comb begin
		lft = 43'(left_q);
		rgt = 43'(right);
		tp  = 43'(top_q);
		bot = 43'(bottom);
		cx[lrc_pkg::LANE_TOP]    = hit_s45[lrc_pkg::LANE_TOP];
		cy[lrc_pkg::LANE_TOP]    = tp;
		cx[lrc_pkg::LANE_LEFT]   = lft;
		cy[lrc_pkg::LANE_LEFT]   = hit_s45[lrc_pkg::LANE_LEFT];
		cx[lrc_pkg::LANE_BOTTOM] = hit_s45[lrc_pkg::LANE_BOTTOM];
		cy[lrc_pkg::LANE_BOTTOM] = bot;
		cx[lrc_pkg::LANE_RIGHT]  = rgt;
		cy[lrc_pkg::LANE_RIGHT]  = hit_s45[lrc_pkg::LANE_RIGHT];
		for (int k = 0; k < lrc_pkg::LANES; k++)
			ok[k] = k[0] ? (cy[k] >= tp && cy[k] <= bot) : (cx[k] >= lft && cx[k] <= rgt);
		e0x = '0;
		e0y = '0;
		e1x = '0;
		e1y = '0;
		crs = 1'b0;
		seen = 1'b0;
		if (!side_s45.line_ok) begin
			crs = 1'b0;
		end else if (side_s45.horiz) begin
			e0x = lft;
			e0y = 43'(side_s45.py);
			e1x = rgt;
			e1y = 43'(side_s45.py);
			crs = e0y >= tp && e0y <= bot;
		end else if (side_s45.vert) begin
			e0x = 43'(side_s45.px);
			e0y = tp;
			e1x = 43'(side_s45.px);
			e1y = bot;
			crs = e0x >= lft && e0x <= rgt;
		end else begin
			// first counted crossing is end0, each later one overwrites end1
			for (int k = 0; k < lrc_pkg::LANES; k++) begin
				if (ok[k]) begin
					if (!seen) begin
						e0x = cx[k];
						e0y = cy[k];
					end else begin
						e1x = cx[k];
						e1y = cy[k];
						crs = 1'b1;
					end
					seen = 1'b1;
				end
			end
		end
	end

	logic               crs_s46;
	logic [127:0]       ends_s46;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_s46 <= 1'b0;
		end else if (en) begin
			out_v_s46 <= v_s45;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			crs_s46 <= crs;
			if (crs)
				ends_s46 <= {lrc_pkg::sat32(e1y), lrc_pkg::sat32(e1x),
					lrc_pkg::sat32(e0y), lrc_pkg::sat32(e0x)};
			else
				ends_s46 <= '0;
		end
	end

	assign m_tvalid   = out_v_s46;
	assign m_tuser[0] = crs_s46;
	assign m_tdata    = ends_s46;

`ifndef SYNTHESIS
	// a result without crossing carries zero ends
	a_zero_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
		else $error("non-crossing result has nonzero ends");

	// an invalid line never reaches the output as crossing
	a_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s45 && !side_s45.line_ok) |=> !m_tuser[0])
		else $error("invalid line flagged as crossing");

	// a stall freezes the valid bits of the first stage and of stage 45
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(v_s1) && $stable(v_s45)))
		else $error("pipeline moved during stall");
`endif

endmodule
